FILE: rtl/rehash_probe_hash_set_defines.svh
// Assertion macros for the rehash probe hash set.
// Included by the top level; needs nothing else.
`ifndef REHASH_PROBE_HASH_SET_DEFINES_SVH
`define REHASH_PROBE_HASH_SET_DEFINES_SVH

`ifndef SYNTH
`define RHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rehash probe hash set: same-cycle check failed");
`define RHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rehash probe hash set: next-cycle check failed");
`else
`define RHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/rhs_pkg.sv
// Shared types and constants of the rehash probe hash set.
// No dependencies; used by every module of the block but rhs_ram.
package rhs_pkg;

    // Request kinds.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_INSERTED = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_ZERO     = 2'd2;
    localparam logic [1:0] STAT_READ     = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SLOTS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PROBES  = 1'd1;
    localparam int CFG_DATA_W = 16;

    localparam logic [10:0] TABLE_SLOTS_RESET = 11'd1024;
    localparam logic [15:0] MAX_PROBES_RESET  = 16'd4096;

    // Hash round constants.
    localparam logic [31:0] HASH_PRIME  = 32'd16777619;
    localparam logic [31:0] HASH_OFFSET = 32'd3141592653;
    localparam int HASH_BYTES = 4;
    localparam int HASH_CNT_W = 2;

    // Remainder unit: 32-bit dividend, four bits retired per cycle.
    localparam int MOD_DVD_BITS  = 32;
    localparam int MOD_STEP_BITS = 4;
    localparam int MOD_STEPS     = MOD_DVD_BITS / MOD_STEP_BITS;
    localparam int MOD_CNT_W     = 3;

    typedef struct packed {
        logic        req_type;
        logic [63:0] element;
        logic [9:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot_used;
        logic [63:0] element_out;
        logic        occupied;
        logic [15:0] probes_used;
    } rsp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] seed;
    } hash_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } hash_rsp_t;

endpackage

FILE: rtl/rhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/rhs_hash.sv
// Byte-wise FNV-1a style hash round, one byte and one multiply per cycle.
// Depends on rhs_pkg.
module rhs_hash (
    input  logic              clk,
    input  logic              rst_n,
    input  rhs_pkg::hash_req_t req,
    output rhs_pkg::hash_rsp_t rsp
);

    import rhs_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [HASH_CNT_W-1:0] step_reg, step_next;
    logic [31:0]           acc_reg, acc_next;
    logic [31:0]           seed_reg, seed_next;
    logic [31:0]           mix;
    logic [31:0]           product;

    assign mix     = acc_reg ^ {24'd0, seed_reg[7:0]};
    assign product = mix * HASH_PRIME;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        seed_next = seed_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            acc_next  = HASH_OFFSET;
            seed_next = req.seed;
        end
        else if (busy_reg)
        begin
            acc_next  = product;
            seed_next = {8'd0, seed_reg[31:8]};
            step_next = step_reg + 1'b1;
            if (step_reg == HASH_CNT_W'(HASH_BYTES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        seed_reg <= seed_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = acc_reg;

endmodule

FILE: rtl/rhs_mod.sv
// Restoring remainder unit: 32-bit dividend modulo a slot count,
// four quotient bits per cycle. Depends on rhs_pkg.
module rhs_mod #(
    parameter int NW = 11
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rhs_pkg::MOD_DVD_BITS-1:0] dividend,
    input  logic [NW-1:0]                   divisor,
    output logic                            done,
    output logic [NW-1:0]                   rem
);

    import rhs_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [MOD_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [MOD_DVD_BITS-1:0] dvd_reg, dvd_next;
    logic [NW-1:0]           div_reg, div_next;
    logic [NW-1:0]           rem_reg, rem_next;
    logic [NW-1:0]           rem_step;

    // Four dependent compare-and-subtract steps; the partial remainder
    // always stays below the divisor, so one subtract per step suffices.
    always_comb
    begin
        logic [NW:0] trial;
        logic [NW-1:0] r;
        r = rem_reg;
        for (int k = 0; k < MOD_STEP_BITS; k++)
        begin
            trial = {r, dvd_reg[MOD_DVD_BITS-1-k]};
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            r = trial[NW-1:0];
        end
        rem_step = r;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            dvd_next = dvd_reg << MOD_STEP_BITS;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/rehash_probe_hash_set.sv
// Rehash probe hash set: open-addressing set of nonzero elements.
// Requests enter on req_valid/req_stall/req_data and results leave on
// rsp_valid/rsp_stall/rsp_data; a request is taken when valid is high and
// stall is low. Configuration writes use cfg_valid/cfg_ready with
// cfg_index and cfg_data; the user must make them only while the block
// is idle, and the block itself does not enforce it. After reset the
// block sweeps the slot memory to empty, one slot a cycle, so req_stall
// stays high until the sweep is done. One request is worked on at a time.
// A read passes the lookup and check states; a zero insert goes straight
// to the done state. Each insert probe passes the hash unit (four multiplies
// and a handoff), the remainder unit (eight steps and a handoff), one memory
// read and one check.
// Results wait in an output register; a new request is accepted while
// the previous result is still stalled there, and the block holds its
// next finished result until the register drains.
// Depends on rhs_pkg, rhs_ram, rhs_hash, rhs_mod and the defines header.
`include "rehash_probe_hash_set_defines.svh"

module rehash_probe_hash_set #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int ELEMENT_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  rhs_pkg::req_t                       req_data,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output rhs_pkg::rsp_t                       rsp_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rhs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rhs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import rhs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_HASH   = 7'b0000100,
        S_MOD    = 7'b0001000,
        S_LOOKUP = 7'b0010000,
        S_CHECK  = 7'b0100000,
        S_DONE   = 7'b1000000
    } seq_state_t;

    seq_state_t              state_reg, state_next;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [10:0]             table_slots_reg;
    logic [15:0]             max_probes_reg;
    logic                    is_read_reg, is_read_next;
    logic                    in_range_reg, in_range_next;
    logic [9:0]              slot_idx_reg, slot_idx_next;
    logic [ELEMENT_BITS-1:0] elem_reg, elem_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic [NW-1:0]           n_reg, n_next;
    logic [31:0]             probe_hash_reg, probe_hash_next;
    logic [15:0]             probe_count_reg, probe_count_next;
    rsp_t                    res_reg, res_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    logic                    req_accept;
    logic                    rsp_load;
    logic [ELEMENT_BITS-1:0] req_elem;
    logic [NW-1:0]           slots_eff;
    logic [31:0]             idx_wide;
    logic [31:0]             addr_wide;

    hash_req_t               hash_req;
    hash_rsp_t               hash_rsp;
    logic                    mod_start;
    logic                    mod_done;
    logic [NW-1:0]           mod_rem;

    logic                    ram_wr_en;
    logic [AW-1:0]           ram_wr_addr;
    logic [ELEMENT_BITS-1:0] ram_wr_data;
    logic                    ram_rd_en;
    logic [ELEMENT_BITS-1:0] ram_rd_data;

    rhs_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    rhs_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hash_req),
        .rsp   (hash_rsp)
    );

    rhs_mod #(
        .NW (NW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (hash_rsp.value),
        .divisor  (n_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_load   = !rsp_valid_reg || !rsp_stall;
    assign cfg_ready  = 1'b1;
    assign req_elem   = req_data.element[ELEMENT_BITS-1:0];
    assign idx_wide   = 32'(req_data.slot_index);
    assign addr_wide  = 32'(addr_reg);

    // A slot count of zero acts as one slot; above the depth it saturates.
    always_comb
    begin
        if (table_slots_reg == 11'd0)
        begin
            slots_eff = NW'(1);
        end
        else if (32'(table_slots_reg) > TABLE_DEPTH)
        begin
            slots_eff = NW'(TABLE_DEPTH);
        end
        else
        begin
            slots_eff = NW'(table_slots_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        is_read_next     = is_read_reg;
        in_range_next    = in_range_reg;
        slot_idx_next    = slot_idx_reg;
        elem_next        = elem_reg;
        addr_next        = addr_reg;
        n_next           = n_reg;
        probe_hash_next  = probe_hash_reg;
        probe_count_next = probe_count_reg;
        res_next         = res_reg;
        hash_req.start   = 1'b0;
        hash_req.seed    = probe_hash_reg;
        mod_start        = 1'b0;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = addr_reg;
        ram_wr_data      = elem_reg;
        ram_rd_en        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_accept)
                begin
                    res_next = '0;
                    if (req_data.req_type == REQ_READ)
                    begin
                        is_read_next  = 1'b1;
                        slot_idx_next = req_data.slot_index;
                        in_range_next = (idx_wide < TABLE_DEPTH);
                        addr_next     = idx_wide[AW-1:0];
                        state_next    = S_LOOKUP;
                    end
                    else if (req_elem == '0)
                    begin
                        res_next.status = STAT_ZERO;
                        state_next      = S_DONE;
                    end
                    else if (max_probes_reg == 16'd0)
                    begin
                        probe_count_next = 16'd0;
                        res_next.status  = STAT_FULL;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        is_read_next     = 1'b0;
                        elem_next        = req_elem;
                        n_next           = slots_eff;
                        probe_count_next = 16'd0;
                        hash_req.start   = 1'b1;
                        hash_req.seed    = req_data.element[31:0];
                        state_next       = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_rsp.done)
                begin
                    probe_hash_next  = hash_rsp.value;
                    probe_count_next = probe_count_reg + 16'd1;
                    mod_start        = 1'b1;
                    state_next       = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    addr_next  = mod_rem[AW-1:0];
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (is_read_reg)
                begin
                    res_next.status    = STAT_READ;
                    res_next.slot_used = slot_idx_reg;
                    if (in_range_reg)
                    begin
                        res_next.element_out = 64'(ram_rd_data);
                        res_next.occupied    = (ram_rd_data != '0);
                    end
                    state_next = S_DONE;
                end
                else if (ram_rd_data == '0)
                begin
                    ram_wr_en            = 1'b1;
                    res_next.status      = STAT_INSERTED;
                    res_next.slot_used   = addr_wide[9:0];
                    res_next.probes_used = probe_count_reg;
                    state_next           = S_DONE;
                end
                else if (probe_count_reg == max_probes_reg)
                begin
                    res_next.status      = STAT_FULL;
                    res_next.probes_used = probe_count_reg;
                    state_next           = S_DONE;
                end
                else
                begin
                    // Slot taken: rehash the last hash and probe again.
                    hash_req.start = 1'b1;
                    state_next     = S_HASH;
                end
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (state_reg == S_DONE && rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res_reg;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            table_slots_reg <= TABLE_SLOTS_RESET;
            max_probes_reg  <= MAX_PROBES_RESET;
            is_read_reg     <= 1'b0;
            probe_hash_reg  <= '0;
            probe_count_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            is_read_reg     <= is_read_next;
            probe_hash_reg  <= probe_hash_next;
            probe_count_reg <= probe_count_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_TABLE_SLOTS: table_slots_reg <= cfg_data[10:0];
                    CFG_MAX_PROBES:  max_probes_reg  <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_range_reg <= in_range_next;
        slot_idx_reg <= slot_idx_next;
        elem_reg     <= elem_next;
        addr_reg     <= addr_next;
        n_reg        <= n_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // An insert may only overwrite a slot that it has just seen empty.
    `RHS_ASSERT_IMPL(a_write_empty_only, clk, rst_n, (state_reg == S_CHECK) && ram_wr_en, ram_rd_data == '0)
    // The hash and remainder units only finish while the sequencer waits on them.
    `RHS_ASSERT_IMPL(a_hash_done_in_hash, clk, rst_n, hash_rsp.done, state_reg == S_HASH)
    `RHS_ASSERT_IMPL(a_mod_done_in_mod, clk, rst_n, mod_done, state_reg == S_MOD)
    // A result handed over from the done state is presented next cycle.
    `RHS_ASSERT_NEXT(a_done_shows_rsp, clk, rst_n, (state_reg == S_DONE) && rsp_load, rsp_valid)

endmodule

FILE: verif/tb_rehash_probe_hash_set.sv
// Self-checking testbench for the rehash probe hash set.
// Drives requests and register writes, predicts each result in place and
// compares it field by field. Depends on rhs_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_rehash_probe_hash_set;
    import rhs_pkg::*;

    localparam int SET_DEPTH = 1024;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the set and of its registers.
    logic [63:0] shadow_slots [SET_DEPTH];
    logic [10:0] cur_table_slots = TABLE_SLOTS_RESET;
    logic [15:0] cur_max_probes = MAX_PROBES_RESET;

    rsp_t pending_results [$];
    int fail_count = 0;
    int req_idle_pct = 0;
    int rsp_stall_pct = 0;

    rehash_probe_hash_set DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < SET_DEPTH; i++)
        begin
            shadow_slots[i] = '0;
        end
    end

    function automatic logic [31:0] fnv_mix_round(logic [31:0] seed);
        logic [31:0] acc;
        logic [31:0] rest;
        acc = HASH_OFFSET;
        rest = seed;
        for (int b = 0; b < 4; b++)
        begin
            acc = acc ^ {24'd0, rest[7:0]};
            acc = acc * HASH_PRIME;
            rest = rest >> 8;
        end
        return acc;
    endfunction

    // Works out the result of one request and applies it to the shadow set.
    function automatic rsp_t predict_set_response(req_t r);
        rsp_t res;
        logic [31:0] h;
        logic [31:0] modulus;
        logic [31:0] pos;
        logic [16:0] rounds;
        logic placed;
        res = '0;
        if (r.req_type == REQ_READ)
        begin
            res.status = STAT_READ;
            res.slot_used = r.slot_index;
            res.element_out = shadow_slots[r.slot_index];
            res.occupied = (shadow_slots[r.slot_index] != 64'd0);
            return res;
        end
        if (r.element == 64'd0)
        begin
            res.status = STAT_ZERO;
            return res;
        end
        if (cur_table_slots == 11'd0)
            modulus = 32'd1;
        else if (cur_table_slots > SET_DEPTH)
            modulus = SET_DEPTH;
        else
            modulus = {21'd0, cur_table_slots};
        h = r.element[31:0];
        rounds = '0;
        placed = 1'b0;
        res.status = STAT_FULL;
        while (!placed && rounds < cur_max_probes)
        begin
            h = fnv_mix_round(h);
            rounds = rounds + 1'b1;
            pos = h % modulus;
            if (shadow_slots[pos[9:0]] == 64'd0)
            begin
                shadow_slots[pos[9:0]] = r.element;
                res.status = STAT_INSERTED;
                res.slot_used = pos[9:0];
                placed = 1'b1;
            end
        end
        res.probes_used = rounds[15:0];
        return res;
    endfunction

    function automatic req_t make_req(logic kind, logic [63:0] elem, logic [9:0] idx);
        req_t r;
        r.req_type = kind;
        r.element = elem;
        r.slot_index = idx;
        return r;
    endfunction

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        req_idle_pct = sender_pct;
        rsp_stall_pct = receiver_pct;
    endtask

    // Valid is left high on return so back-to-back requests need no gap.
    task automatic issue_request(input req_t r, output rsp_t want);
        if ($urandom_range(99) < req_idle_pct)
        begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do @(posedge clk); while (req_stall);
        want = predict_set_response(r);
        pending_results.push_back(want);
    endtask

    task automatic wait_drain();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [15:0] slots, input logic [15:0] probes);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TABLE_SLOTS;
        cfg_data <= slots;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_MAX_PROBES;
        cfg_data <= probes;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_table_slots = slots[10:0];
        cur_max_probes = probes;
    endtask

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request waiting: status %0d", rsp_data.status);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                    fail_count++;
                end
                if (rsp_data.slot_used !== want.slot_used)
                begin
                    $error("slot_used: expected %0d, got %0d",
                           want.slot_used, rsp_data.slot_used);
                    fail_count++;
                end
                if (rsp_data.element_out !== want.element_out)
                begin
                    $error("element_out: expected %h, got %h",
                           want.element_out, rsp_data.element_out);
                    fail_count++;
                end
                if (rsp_data.occupied !== want.occupied)
                begin
                    $error("occupied: expected %0d, got %0d", want.occupied, rsp_data.occupied);
                    fail_count++;
                end
                if (rsp_data.probes_used !== want.probes_used)
                begin
                    $error("probes_used: expected %0d, got %0d",
                           want.probes_used, rsp_data.probes_used);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_empty_reads();
        rsp_t e;
        issue_request(make_req(REQ_READ, 64'd0, 10'd0), e);
        issue_request(make_req(REQ_READ, '1, 10'h3FF), e);
    endtask

    task automatic test_insert_cases(output logic [9:0] far_slot);
        rsp_t e;
        logic [9:0] slot_ones;
        logic [9:0] slot_one;
        logic [9:0] slot_high;
        issue_request(make_req(REQ_INSERT, '1, 10'd0), e);
        slot_ones = e.slot_used;
        issue_request(make_req(REQ_INSERT, 64'd1, 10'h3FF), e);
        slot_one = e.slot_used;
        // A repeated element is not detected and takes a second slot.
        issue_request(make_req(REQ_INSERT, 64'd1, 10'd0), e);
        // Low half zero: the hash seed is zero but the element is valid.
        issue_request(make_req(REQ_INSERT, 64'hFFFF_FFFF_0000_0000, 10'd0), e);
        slot_high = e.slot_used;
        issue_request(make_req(REQ_INSERT, 64'h8000_0000_0000_0000, 10'h155), e);
        issue_request(make_req(REQ_INSERT, 64'd0, 10'h3FF), e);
        issue_request(make_req(REQ_READ, '1, slot_ones), e);
        issue_request(make_req(REQ_READ, 64'd0, slot_one), e);
        issue_request(make_req(REQ_READ, 64'd0, slot_high), e);
        far_slot = (slot_ones > slot_one) ? slot_ones : slot_one;
    endtask

    task automatic test_register_extremes(input logic [9:0] far_slot);
        rsp_t e;
        // A slot count of zero acts as one slot, so the second insert gives up.
        write_config(16'd0, 16'd3);
        issue_request(make_req(REQ_INSERT, 64'h1234_5678_9ABC_DEF0, 10'd0), e);
        issue_request(make_req(REQ_INSERT, 64'h0F0F_0F0F_F0F0_F0F0, 10'd0), e);
        issue_request(make_req(REQ_READ, 64'd0, 10'd0), e);
        // No probes allowed; slots beyond the count still read their content.
        write_config(16'd1, 16'd0);
        issue_request(make_req(REQ_INSERT, 64'h5555_5555_AAAA_AAAA, 10'd0), e);
        issue_request(make_req(REQ_INSERT, 64'd0, 10'd0), e);
        issue_request(make_req(REQ_READ, 64'd0, far_slot), e);
        write_config(16'd2, 16'd1);
        for (int i = 0; i < 3; i++)
        begin
            issue_request(make_req(REQ_INSERT, {$urandom, $urandom}, 10'd0), e);
        end
        // A count above the depth acts as the full depth.
        write_config(16'd2047, 16'hFFFF);
        issue_request(make_req(REQ_INSERT, {$urandom, $urandom}, 10'd0), e);
        issue_request(make_req(REQ_INSERT, {$urandom, $urandom}, 10'd0), e);
        issue_request(make_req(REQ_READ, 64'd0, 10'h3FF), e);
    endtask

    task automatic run_random_round(input int count);
        req_t r;
        rsp_t e;
        logic [63:0] last_elem;
        logic [9:0] last_slot;
        int pick;
        last_elem = 64'd1;
        last_slot = '0;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            r.req_type = REQ_INSERT;
            r.element = {$urandom, $urandom};
            r.slot_index = 10'($urandom_range(SET_DEPTH - 1));
            if (pick < 8)
                r.element = '0;
            else if (pick < 12)
                r.element[31:0] = '0;
            else if (pick < 20)
                r.element = last_elem;
            else if (pick < 35)
            begin
                r.req_type = REQ_READ;
                r.slot_index = last_slot;
            end
            else if (pick < 55)
                r.req_type = REQ_READ;
            issue_request(r, e);
            if (e.status == STAT_INSERTED)
            begin
                last_elem = r.element;
                last_slot = e.slot_used;
            end
        end
    endtask

    task automatic test_random_traffic();
        set_idling(17, 76);
        write_config(16'd1024, 16'd4096);
        run_random_round(150);
        // Upper data bits beyond the register width are dropped: 37 slots.
        set_idling(76, 17);
        write_config(16'hF825, 16'd16);
        run_random_round(150);
        set_idling(0, 0);
        write_config(16'd2047, 16'hFFFF);
        run_random_round(150);
    endtask

    initial
    begin
        logic [9:0] far_slot;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(17, 76);
        test_empty_reads();
        test_insert_cases(far_slot);
        test_register_extremes(far_slot);
        test_random_traffic();
        wait_drain();
        repeat (64) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule
